// ===== rtl/cas_pkg.sv =====
package cas_pkg;

    // sizing
    localparam int MAX_FRAMES = 64;
    localparam int POS_W      = 16;
    localparam int PTS_W      = 16;
    localparam int SPREAD_W   = 16;
    localparam int FC_W       = 7;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = 3 * POS_W;

    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SUM_W   = POS_W + $clog2(MAX_FRAMES);
    localparam int DX_W    = SUM_W + 2;
    localparam int MAG_W   = DX_W - 1;
    localparam int D_W     = 2 * MAG_W;
    localparam int ROOT_W  = D_W / 2;
    localparam int SQ_C_W  = $clog2(ROOT_W + 1);
    localparam int DIV_N_W = (ROOT_W > SUM_W + 1) ? ROOT_W : SUM_W + 1;
    localparam int DIV_D_W = CNT_W + 1;
    localparam int DIV_C_W = $clog2(DIV_N_W + 1);
    localparam int LIM_W   = CFG_W + CNT_W;
    localparam int LSQ_W   = 2 * LIM_W;
    localparam int CMP_W   = (D_W > LSQ_W) ? D_W : LSQ_W;
    localparam int TGT_W   = (FC_W > CNT_W) ? FC_W : CNT_W;

    // item kinds
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD  = 1'b1;

    localparam logic [FC_W-1:0]  FRAME_COUNT_RESET = 7'd15;
    localparam logic [CFG_W-1:0] MAX_SPREAD_RESET  = 16'd250;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_WALK,
        ST_DRAIN,
        ST_SQRT,
        ST_SPREAD,
        ST_FINISH
    } cas_state_t;

    typedef struct packed {
        logic frame_wr;
        logic restart;
        logic start;
        logic walk_issue;
        logic sqrt_start;
        logic spread_start;
        logic out_load;
    } cas_cmd_t;

    typedef struct packed {
        logic set_full;
        logic store_full;
        logic walk_last;
        logic pipe_empty;
        logic sqrt_busy;
        logic div_busy;
    } cas_status_t;

endpackage

// ===== rtl/cas_ram.sv =====
module cas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cas_div.sv =====
module cas_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cas_pkg::DIV_N_W-1:0] num,
    input  logic [cas_pkg::DIV_D_W-1:0] den,
    output logic                        busy,
    output logic [cas_pkg::DIV_N_W-1:0] quot
);

    // restoring divider, one quotient bit a cycle
    logic                        busy_reg;
    logic [cas_pkg::DIV_C_W-1:0] cnt_reg;
    logic [cas_pkg::DIV_N_W-1:0] num_reg;
    logic [cas_pkg::DIV_D_W-1:0] den_reg;
    logic [cas_pkg::DIV_D_W-1:0] rem_reg;

    logic [cas_pkg::DIV_D_W:0]   shifted;
    logic [cas_pkg::DIV_D_W:0]   diff;
    logic                        ge;
    logic [cas_pkg::DIV_D_W-1:0] rem_next;
    logic [cas_pkg::DIV_N_W-1:0] num_next;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[cas_pkg::DIV_N_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[cas_pkg::DIV_D_W-1:0] : shifted[cas_pkg::DIV_D_W-1:0];
        num_next = {num_reg[cas_pkg::DIV_N_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cas_pkg::DIV_C_W'(cas_pkg::DIV_N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - cas_pkg::DIV_C_W'(1);
            if (cnt_reg == cas_pkg::DIV_C_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

// ===== rtl/cas_datapath.sv =====
module cas_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cas_pkg::cas_cmd_t                  cmd,
    output cas_pkg::cas_status_t               status,
    input  logic [cas_pkg::FC_W-1:0]           frame_count,
    input  logic [cas_pkg::CFG_W-1:0]          max_spread,
    input  logic signed [cas_pkg::POS_W-1:0]   pos_x,
    input  logic signed [cas_pkg::POS_W-1:0]   pos_y,
    input  logic signed [cas_pkg::POS_W-1:0]   pos_z,
    input  logic [cas_pkg::PTS_W-1:0]          point_count,
    output logic signed [cas_pkg::POS_W-1:0]   mean_x,
    output logic signed [cas_pkg::POS_W-1:0]   mean_y,
    output logic signed [cas_pkg::POS_W-1:0]   mean_z,
    output logic [cas_pkg::SPREAD_W-1:0]       spread,
    output logic [cas_pkg::PTS_W-1:0]          last_points,
    output logic                               spread_ok
);

    localparam int POS_W  = cas_pkg::POS_W;
    localparam int SUM_W  = cas_pkg::SUM_W;
    localparam int CNT_W  = cas_pkg::CNT_W;
    localparam int ADDR_W = cas_pkg::ADDR_W;
    localparam int DX_W   = cas_pkg::DX_W;
    localparam int MAG_W  = cas_pkg::MAG_W;
    localparam int D_W    = cas_pkg::D_W;
    localparam int ROOT_W = cas_pkg::ROOT_W;
    localparam int DN_W   = cas_pkg::DIV_N_W;
    localparam int DD_W   = cas_pkg::DIV_D_W;
    localparam int TGT_W  = cas_pkg::TGT_W;

    function automatic logic [POS_W-1:0] apply_sign(input logic neg,
                                                    input logic [DN_W-1:0] q);
        logic [DN_W-1:0] v;
        v = neg ? (~q + DN_W'(1)) : q;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] abs_dx(input logic signed [DX_W-1:0] d);
        logic [DX_W-1:0] v;
        v = d[DX_W-1] ? (~d + DX_W'(1)) : d;
        return v[MAG_W-1:0];
    endfunction

    // set accumulation
    logic [CNT_W-1:0]        held_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic signed [SUM_W-1:0] sum_z_reg;
    logic [POS_W-1:0]        final_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_z_reg        <= '0;
            final_points_reg <= '0;
        end
        else if (cmd.restart || cmd.out_load)
        begin
            held_reg  <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end
        else if (cmd.frame_wr)
        begin
            held_reg         <= held_reg + CNT_W'(1);
            sum_x_reg        <= sum_x_reg + SUM_W'(pos_x);
            sum_y_reg        <= sum_y_reg + SUM_W'(pos_y);
            sum_z_reg        <= sum_z_reg + SUM_W'(pos_z);
            final_points_reg <= point_count;
        end
    end

    // effective frame target
    logic [TGT_W-1:0] fc_ext;
    logic [TGT_W-1:0] target;

    always_comb
    begin
        fc_ext = TGT_W'(frame_count);
        if (fc_ext == '0)
        begin
            target = TGT_W'(1);
        end
        else if (fc_ext > TGT_W'(cas_pkg::MAX_FRAMES))
        begin
            target = TGT_W'(cas_pkg::MAX_FRAMES);
        end
        else
        begin
            target = fc_ext;
        end
    end

    // frame store
    logic [cas_pkg::ENTRY_W-1:0] entry_wr;
    logic [cas_pkg::ENTRY_W-1:0] entry_rd;
    logic [ADDR_W-1:0]           walk_addr_reg;

    assign entry_wr = {pos_z, pos_y, pos_x};

    cas_ram #(
        .WIDTH (cas_pkg::ENTRY_W),
        .DEPTH (cas_pkg::MAX_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.frame_wr),
        .waddr (held_reg[ADDR_W-1:0]),
        .wdata (entry_wr),
        .re    (cmd.walk_issue),
        .raddr (walk_addr_reg),
        .rdata (entry_rd)
    );

    // set snapshot at start
    logic [CNT_W-1:0]            n_reg;
    logic                        neg_x_reg;
    logic                        neg_y_reg;
    logic                        neg_z_reg;
    logic [cas_pkg::LIM_W-1:0]   lim_reg;
    logic [cas_pkg::LSQ_W-1:0]   limsq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg     <= held_reg;
            neg_x_reg <= sum_x_reg[SUM_W-1];
            neg_y_reg <= sum_y_reg[SUM_W-1];
            neg_z_reg <= sum_z_reg[SUM_W-1];
            lim_reg   <= cas_pkg::LIM_W'(max_spread) * cas_pkg::LIM_W'(held_reg);
        end
        limsq_reg <= cas_pkg::LSQ_W'(lim_reg) * cas_pkg::LSQ_W'(lim_reg);
    end

    // deviation walk: read, scale and subtract, square, max
    logic              rd_v_reg;
    logic              dx_v_reg;
    logic              sq_v_reg;
    logic [MAG_W-1:0]  mx_reg;
    logic [MAG_W-1:0]  my_reg;
    logic [MAG_W-1:0]  mz_reg;
    logic [D_W-1:0]    sqx_reg;
    logic [D_W-1:0]    sqy_reg;
    logic [D_W-1:0]    sqz_reg;
    logic [D_W-1:0]    dmax_reg;

    logic signed [DX_W-1:0] n_s;
    logic signed [DX_W-1:0] dx_next;
    logic signed [DX_W-1:0] dy_next;
    logic signed [DX_W-1:0] dz_next;
    logic [D_W-1:0]         dsum;

    always_comb
    begin
        n_s     = DX_W'($signed({1'b0, n_reg}));
        dx_next = n_s * DX_W'($signed(entry_rd[POS_W-1:0])) - DX_W'(sum_x_reg);
        dy_next = n_s * DX_W'($signed(entry_rd[2*POS_W-1:POS_W])) - DX_W'(sum_y_reg);
        dz_next = n_s * DX_W'($signed(entry_rd[3*POS_W-1:2*POS_W])) - DX_W'(sum_z_reg);
        dsum    = sqx_reg + sqy_reg + sqz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            dx_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.walk_issue;
            dx_v_reg <= rd_v_reg;
            sq_v_reg <= dx_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            walk_addr_reg <= '0;
        end
        else if (cmd.walk_issue)
        begin
            walk_addr_reg <= walk_addr_reg + ADDR_W'(1);
        end
        mx_reg  <= abs_dx(dx_next);
        my_reg  <= abs_dx(dy_next);
        mz_reg  <= abs_dx(dz_next);
        sqx_reg <= D_W'(mx_reg) * D_W'(mx_reg);
        sqy_reg <= D_W'(my_reg) * D_W'(my_reg);
        sqz_reg <= D_W'(mz_reg) * D_W'(mz_reg);
        if (cmd.start)
        begin
            dmax_reg <= '0;
        end
        else if (sq_v_reg && (dsum > dmax_reg))
        begin
            dmax_reg <= dsum;
        end
    end

    // square root, one result bit a cycle
    logic                       sqrt_busy_reg;
    logic [cas_pkg::SQ_C_W-1:0] sqrt_cnt_reg;
    logic [D_W-1:0]             rad_reg;
    logic [ROOT_W+1:0]          srem_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic                       ok_reg;

    logic [ROOT_W+1:0] srem_sh;
    logic [ROOT_W+1:0] trial;
    logic              sge;

    always_comb
    begin
        srem_sh = {srem_reg[ROOT_W-1:0], rad_reg[D_W-1:D_W-2]};
        trial   = {root_reg, 2'b01};
        sge     = (srem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
            sqrt_cnt_reg  <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sqrt_busy_reg <= 1'b1;
            sqrt_cnt_reg  <= cas_pkg::SQ_C_W'(ROOT_W);
        end
        else if (sqrt_busy_reg)
        begin
            sqrt_cnt_reg <= sqrt_cnt_reg - cas_pkg::SQ_C_W'(1);
            if (sqrt_cnt_reg == cas_pkg::SQ_C_W'(1))
            begin
                sqrt_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg  <= dmax_reg;
            srem_reg <= '0;
            root_reg <= '0;
            ok_reg   <= (cas_pkg::CMP_W'(dmax_reg) <= cas_pkg::CMP_W'(limsq_reg));
        end
        else if (sqrt_busy_reg)
        begin
            rad_reg  <= {rad_reg[D_W-3:0], 2'b00};
            srem_reg <= sge ? (srem_sh - trial) : srem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], sge};
        end
    end

    // dividers: three lanes for the means, lane 0 reused for the spread
    logic [DN_W-1:0] num_x;
    logic [DN_W-1:0] num_y;
    logic [DN_W-1:0] num_z;
    logic [DD_W-1:0] den_mean;
    logic [DN_W-1:0] num0;
    logic [DD_W-1:0] den0;
    logic [DN_W-1:0] q0;
    logic [DN_W-1:0] q1;
    logic [DN_W-1:0] q2;
    logic            busy0;
    logic            busy1;
    logic            busy2;

    always_comb
    begin
        num_x    = DN_W'({magnitude(sum_x_reg), 1'b0}) + DN_W'(held_reg);
        num_y    = DN_W'({magnitude(sum_y_reg), 1'b0}) + DN_W'(held_reg);
        num_z    = DN_W'({magnitude(sum_z_reg), 1'b0}) + DN_W'(held_reg);
        den_mean = {held_reg, 1'b0};
        num0     = cmd.spread_start ? DN_W'(root_reg) : num_x;
        den0     = cmd.spread_start ? DD_W'(n_reg) : den_mean;
    end

    cas_div u_div0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start || cmd.spread_start),
        .num   (num0),
        .den   (den0),
        .busy  (busy0),
        .quot  (q0)
    );

    cas_div u_div1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .num   (num_y),
        .den   (den_mean),
        .busy  (busy1),
        .quot  (q1)
    );

    cas_div u_div2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .num   (num_z),
        .den   (den_mean),
        .busy  (busy2),
        .quot  (q2)
    );

    // result assembly
    logic [POS_W-1:0]            mean_x_q_reg;
    logic [POS_W-1:0]            mean_x_reg;
    logic [POS_W-1:0]            mean_y_reg;
    logic [POS_W-1:0]            mean_z_reg;
    logic [cas_pkg::SPREAD_W-1:0] spread_reg;
    logic [cas_pkg::PTS_W-1:0]    last_points_reg;
    logic                         spread_ok_reg;
    logic [cas_pkg::SPREAD_W-1:0] spread_sat;

    assign spread_sat = (|q0[DN_W-1:cas_pkg::SPREAD_W]) ? '1 : q0[cas_pkg::SPREAD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.spread_start)
        begin
            mean_x_q_reg <= apply_sign(neg_x_reg, q0);
        end
        if (cmd.out_load)
        begin
            mean_x_reg      <= mean_x_q_reg;
            mean_y_reg      <= apply_sign(neg_y_reg, q1);
            mean_z_reg      <= apply_sign(neg_z_reg, q2);
            spread_reg      <= spread_sat;
            last_points_reg <= final_points_reg;
            spread_ok_reg   <= ok_reg;
        end
    end

    assign mean_x      = $signed(mean_x_reg);
    assign mean_y      = $signed(mean_y_reg);
    assign mean_z      = $signed(mean_z_reg);
    assign spread      = spread_reg;
    assign last_points = last_points_reg;
    assign spread_ok   = spread_ok_reg;

    always_comb
    begin
        status.set_full   = (TGT_W'(held_reg) >= target);
        status.store_full = (held_reg == CNT_W'(cas_pkg::MAX_FRAMES));
        status.walk_last  = (CNT_W'(walk_addr_reg) == (n_reg - CNT_W'(1)));
        status.pipe_empty = !rd_v_reg && !dx_v_reg && !sq_v_reg;
        status.sqrt_busy  = sqrt_busy_reg;
        status.div_busy   = busy0 || busy1 || busy2;
    end

endmodule

// ===== rtl/cas_ctrl.sv =====
module cas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 kind,
    input  logic                 out_stall,
    input  cas_pkg::cas_status_t status,
    output cas_pkg::cas_cmd_t    cmd,
    output logic                 in_stall,
    output logic                 out_valid
);

    cas_pkg::cas_state_t state_reg;
    cas_pkg::cas_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;
    logic                out_free;
    logic                units_idle;

    assign accept     = in_valid && (state_reg == cas_pkg::ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign units_idle = !status.sqrt_busy && !status.div_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cas_pkg::ST_IDLE:
            begin
                if (accept && (kind == cas_pkg::KIND_FRAME))
                begin
                    state_next = cas_pkg::ST_CHECK;
                end
            end
            cas_pkg::ST_CHECK:
            begin
                state_next = status.set_full ? cas_pkg::ST_START : cas_pkg::ST_IDLE;
            end
            cas_pkg::ST_START:
            begin
                state_next = cas_pkg::ST_WALK;
            end
            cas_pkg::ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = cas_pkg::ST_DRAIN;
                end
            end
            cas_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = cas_pkg::ST_SQRT;
                end
            end
            cas_pkg::ST_SQRT:
            begin
                if (units_idle)
                begin
                    state_next = cas_pkg::ST_SPREAD;
                end
            end
            cas_pkg::ST_SPREAD:
            begin
                if (!status.div_busy)
                begin
                    state_next = cas_pkg::ST_FINISH;
                end
            end
            cas_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = cas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != cas_pkg::ST_IDLE);
        case (state_reg)
            cas_pkg::ST_IDLE:
            begin
                cmd.frame_wr = accept && (kind == cas_pkg::KIND_FRAME);
                cmd.restart  = accept && (kind == cas_pkg::KIND_RESTART);
            end
            cas_pkg::ST_START:
            begin
                cmd.start = 1'b1;
            end
            cas_pkg::ST_WALK:
            begin
                cmd.walk_issue = 1'b1;
            end
            cas_pkg::ST_DRAIN:
            begin
                cmd.sqrt_start = status.pipe_empty;
            end
            cas_pkg::ST_SQRT:
            begin
                cmd.spread_start = units_idle;
            end
            cas_pkg::ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cas_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/centroid_average_spread_check.sv =====
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | input     | in_valid / in_stall  | kind, pos_x, pos_y, pos_z, point_count
// out     | output    | out_valid / out_stall| mean_x/y/z, spread, last_points, spread_ok
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// a frame that does not complete a set stalls input only for the set check, a restart not at all
// a completing frame of an n-frame set runs the deviation walk, which
//   reads one stored frame a cycle through the store's single read port,
//   then the bit-serial square root and the spread divide run in turn
// reset (rst_n low, asynchronous) empties the set and loads the register defaults
// results wait in an output register; new transactions are taken while one waits,
//   and only a second completed set holds off until the output is taken
module centroid_average_spread_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_x,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_y,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_z,
    input  logic [cas_pkg::PTS_W-1:0]           point_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cas_pkg::POS_W-1:0]    mean_x,
    output logic signed [cas_pkg::POS_W-1:0]    mean_y,
    output logic signed [cas_pkg::POS_W-1:0]    mean_z,
    output logic [cas_pkg::SPREAD_W-1:0]        spread,
    output logic [cas_pkg::PTS_W-1:0]           last_points,
    output logic                                spread_ok,
    input  logic                                cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cas_pkg::CFG_W-1:0]           cfg_data
);

    // configuration registers
    logic [cas_pkg::FC_W-1:0]  frame_count_reg;
    logic [cas_pkg::CFG_W-1:0] max_spread_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= cas_pkg::FRAME_COUNT_RESET;
            max_spread_reg  <= cas_pkg::MAX_SPREAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cas_pkg::CFG_FRAME_COUNT:
                begin
                    frame_count_reg <= cfg_data[cas_pkg::FC_W-1:0];
                end
                cas_pkg::CFG_MAX_SPREAD:
                begin
                    max_spread_reg <= cfg_data;
                end
                default:
                begin
                    frame_count_reg <= frame_count_reg;
                end
            endcase
        end
    end

    // controller and datapath talk only through these
    cas_pkg::cas_cmd_t    cmd;
    cas_pkg::cas_status_t status;

    // sequencing: accept, set check, walk, square root, spread divide, load result
    cas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // frame store, sums, deviation pipeline, root and dividers, result register
    cas_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .frame_count (frame_count_reg),
        .max_spread  (max_spread_reg),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_count (point_count),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .mean_z      (mean_z),
        .spread      (spread),
        .last_points (last_points),
        .spread_ok   (spread_ok)
    );

    // a finished result never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result loaded over a pending output transaction");

    // a set always completes before the store runs out of entries
    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_wr |-> !status.store_full)
        else $error("frame written into a full store");

    // a restart transaction never produces a result of its own
    a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == cas_pkg::KIND_RESTART)) |=> !$rose(out_valid))
        else $error("result raised right after a restart");

endmodule

// ===== sim/centroid_average_checker.sv =====
module centroid_average_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                kind,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_x,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_y,
    input  logic signed [cas_pkg::POS_W-1:0]    pos_z,
    input  logic [cas_pkg::PTS_W-1:0]           point_count,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [cas_pkg::POS_W-1:0]    mean_x,
    input  logic signed [cas_pkg::POS_W-1:0]    mean_y,
    input  logic signed [cas_pkg::POS_W-1:0]    mean_z,
    input  logic [cas_pkg::SPREAD_W-1:0]        spread,
    input  logic [cas_pkg::PTS_W-1:0]           last_points,
    input  logic                                spread_ok,
    input  logic                                cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cas_pkg::CFG_W-1:0]           cfg_data,
    output int                                  fail_count,
    output int                                  pending_results
);

    localparam int POS_W      = cas_pkg::POS_W;
    localparam int PTS_W      = cas_pkg::PTS_W;
    localparam int SPREAD_W   = cas_pkg::SPREAD_W;
    localparam int FC_W       = cas_pkg::FC_W;
    localparam int CFG_W      = cas_pkg::CFG_W;
    localparam int ADDR_W     = cas_pkg::ADDR_W;
    localparam int MAX_FRAMES = cas_pkg::MAX_FRAMES;

    typedef struct packed {
        logic [POS_W-1:0]    mx;
        logic [POS_W-1:0]    my;
        logic [POS_W-1:0]    mz;
        logic [SPREAD_W-1:0] spread;
        logic [PTS_W-1:0]    points;
        logic                ok;
    } measurement_t;

    measurement_t   expected_measurements[$];

    // shadow of the frame set and the registers
    shortint        held_x [MAX_FRAMES];
    shortint        held_y [MAX_FRAMES];
    shortint        held_z [MAX_FRAMES];
    int             held_count;
    longint         acc_x;
    longint         acc_y;
    longint         acc_z;
    logic [PTS_W-1:0] last_pts;
    logic [FC_W-1:0]  cfg_frames;
    logic [CFG_W-1:0] cfg_limit;

    // mean rounded to nearest, ties away from zero
    function automatic logic [POS_W-1:0] rounded_mean(longint s, longint n);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = (2 * mag + n) / (2 * n);
        return (s < 0) ? POS_W'(-q) : POS_W'(q);
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int                target;
        longint            n;
        longint            dx;
        longint            dy;
        longint            dz;
        longint unsigned   d;
        longint unsigned   dmax;
        longint unsigned   lim;
        longint unsigned   rem;
        longint unsigned   root;
        longint unsigned   bitv;
        longint unsigned   sp;
        measurement_t      m;
        if (!rst_n)
        begin
            expected_measurements.delete();
            held_count = 0;
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            last_pts = '0;
            cfg_frames = cas_pkg::FRAME_COUNT_RESET;
            cfg_limit = cas_pkg::MAX_SPREAD_RESET;
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            // result side first: a result never comes from the item taken at this edge
            if (out_valid && !out_stall)
            begin
                if (expected_measurements.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, %s %0d %0d %0d %0d %0d %0d",
                             $time, "actual", mean_x, mean_y, mean_z, spread, last_points,
                             spread_ok);
                    fail_count++;
                end
                else
                begin
                    m = expected_measurements[0];
                    expected_measurements.delete(0);
                    fail_count += field_differs("mean_x", $signed(m.mx), mean_x)
                                + field_differs("mean_y", $signed(m.my), mean_y)
                                + field_differs("mean_z", $signed(m.mz), mean_z)
                                + field_differs("spread", m.spread, spread)
                                + field_differs("last_points", m.points, last_points)
                                + field_differs("spread_ok", m.ok, spread_ok);
                end
            end

            if (in_valid && !in_stall)
            begin
                if (kind == cas_pkg::KIND_RESTART)
                begin
                    held_count = 0;
                    acc_x = 0;
                    acc_y = 0;
                    acc_z = 0;
                end
                else
                begin
                    target = (cfg_frames == '0) ? 1 : int'(cfg_frames);
                    if (target > MAX_FRAMES)
                        target = MAX_FRAMES;
                    if (held_count < MAX_FRAMES)
                    begin
                        held_x[ADDR_W'(held_count)] = pos_x;
                        held_y[ADDR_W'(held_count)] = pos_y;
                        held_z[ADDR_W'(held_count)] = pos_z;
                        held_count++;
                        acc_x += pos_x;
                        acc_y += pos_y;
                        acc_z += pos_z;
                    end
                    last_pts = point_count;

                    if (held_count >= target)
                    begin
                        // squared distance scaled by n squared, exact in integers
                        n = held_count;
                        dmax = 0;
                        for (int i = 0; i < held_count; i++)
                        begin
                            dx = n * longint'(held_x[ADDR_W'(i)]) - acc_x;
                            dy = n * longint'(held_y[ADDR_W'(i)]) - acc_y;
                            dz = n * longint'(held_z[ADDR_W'(i)]) - acc_z;
                            d = dx * dx + dy * dy + dz * dz;
                            if (d > dmax)
                                dmax = d;
                        end

                        // floor square root, two bits at a time
                        rem = dmax;
                        root = 0;
                        bitv = 64'd1 << 62;
                        while (bitv > rem)
                            bitv >>= 2;
                        while (bitv != 0)
                        begin
                            if (rem >= root + bitv)
                            begin
                                rem -= root + bitv;
                                root = (root >> 1) + bitv;
                            end
                            else
                                root >>= 1;
                            bitv >>= 2;
                        end

                        sp = root / n;
                        if (sp > 64'hFFFF)
                            sp = 64'hFFFF;
                        lim = longint'(cfg_limit) * n;

                        m.mx = rounded_mean(acc_x, n);
                        m.my = rounded_mean(acc_y, n);
                        m.mz = rounded_mean(acc_z, n);
                        m.spread = sp[SPREAD_W-1:0];
                        m.points = last_pts;
                        m.ok = (dmax <= lim * lim);
                        expected_measurements = {expected_measurements, m};

                        held_count = 0;
                        acc_x = 0;
                        acc_y = 0;
                        acc_z = 0;
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == cas_pkg::CFG_FRAME_COUNT)
                    cfg_frames = cfg_data[FC_W-1:0];
                else if (cfg_index == cas_pkg::CFG_MAX_SPREAD)
                    cfg_limit = cfg_data;
            end

            pending_results = expected_measurements.size();
        end
    end

endmodule

// ===== sim/tb_centroid_average_spread_check.sv =====
module tb_centroid_average_spread_check;

    localparam int POS_W      = cas_pkg::POS_W;
    localparam int PTS_W      = cas_pkg::PTS_W;
    localparam int SPREAD_W   = cas_pkg::SPREAD_W;
    localparam int FC_W       = cas_pkg::FC_W;
    localparam int CFG_W      = cas_pkg::CFG_W;
    localparam int CFG_IDX_W  = cas_pkg::CFG_IDX_W;
    localparam int MAX_FRAMES = cas_pkg::MAX_FRAMES;

    // clock and reset
    logic                       clk = 1'b0;
    logic                       rst_n;

    // input channel
    logic                       in_valid;
    logic                       in_stall;
    logic                       kind;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [POS_W-1:0]    pos_z;
    logic [PTS_W-1:0]           point_count;

    // output channel
    logic                       out_valid;
    logic                       out_stall;
    logic signed [POS_W-1:0]    mean_x;
    logic signed [POS_W-1:0]    mean_y;
    logic signed [POS_W-1:0]    mean_z;
    logic [SPREAD_W-1:0]        spread;
    logic [PTS_W-1:0]           last_points;
    logic                       spread_ok;

    // register write port
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    // from the checker
    int                         fail_count;
    int                         pending_results;

    // idle odds in percent, and the count of receiver hold-off requests
    int unsigned                tx_idle_pct;
    int unsigned                rx_idle_pct;
    int unsigned                hold_req;

    always #5 clk = ~clk;

    centroid_average_spread_check dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .point_count (point_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean_x      (mean_x),
        .mean_y      (mean_y),
        .mean_z      (mean_z),
        .spread      (spread),
        .last_points (last_points),
        .spread_ok   (spread_ok),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    centroid_average_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .point_count     (point_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_x          (mean_x),
        .mean_y          (mean_y),
        .mean_z          (mean_z),
        .spread          (spread),
        .last_points     (last_points),
        .spread_ok       (spread_ok),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // receiver: random stall, or a long hold-off counted here once requested
    initial
    begin : receiver
        int unsigned hold_seen;
        int          hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_left = 400;
                hold_seen = hold_req;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // one input transaction: random gaps first, then hold until taken
    task automatic send_item(input logic k, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                             input logic [PTS_W-1:0] pts);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        point_count <= pts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid, wait for every expected result, then let the block go quiet
    task automatic settle(input int quiet_cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (quiet_cycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // a coordinate scattered around a center, wrapping at 16 bits
    function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] c, int unsigned jit);
        return c + POS_W'($urandom_range(2 * jit)) - POS_W'(jit);
    endfunction

    initial
    begin
        int unsigned      random_items;
        int unsigned      phase;
        int               target;
        int               len;
        int unsigned      jit;
        logic [FC_W-1:0]  fc;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;

        // every input known from time zero
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = cas_pkg::KIND_FRAME;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        point_count = '0;
        cfg_we = 1'b0;
        cfg_index = cas_pkg::CFG_FRAME_COUNT;
        cfg_data = '0;
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        hold_req = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single-frame sets at the field extremes, zero limit
        settle(4);
        write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd1);
        write_reg(cas_pkg::CFG_MAX_SPREAD, 16'd0);
        send_item(cas_pkg::KIND_FRAME, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(cas_pkg::KIND_FRAME, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_item(cas_pkg::KIND_FRAME, 16'h8000, 16'h7FFF, 16'h0000, 16'h5A5A);
        // restart with nothing stored
        send_item(cas_pkg::KIND_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // two-frame sets: widest spread, rounding ties both signs, restart mid-set
        settle(16);
        write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd2);
        write_reg(cas_pkg::CFG_MAX_SPREAD, 16'hFFFF);
        send_item(cas_pkg::KIND_FRAME, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
        send_item(cas_pkg::KIND_FRAME, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0002);
        send_item(cas_pkg::KIND_FRAME, 16'h0001, 16'hFFFF, 16'h0000, 16'h00A5);
        send_item(cas_pkg::KIND_FRAME, 16'h0000, 16'h0000, 16'hFFFF, 16'hA500);
        send_item(cas_pkg::KIND_FRAME, 16'd100, 16'd200, 16'd300, 16'd7);
        send_item(cas_pkg::KIND_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(cas_pkg::KIND_FRAME, 16'd10, 16'd20, 16'd30, 16'd8);
        send_item(cas_pkg::KIND_FRAME, 16'd14, 16'd17, 16'd30, 16'd9);

        // frame count zero acts as one
        settle(16);
        write_reg(cas_pkg::CFG_MAX_SPREAD, 16'd0);
        write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd0);
        send_item(cas_pkg::KIND_FRAME, 16'd5, 16'd5, 16'd5, 16'd3);

        // frame count lowered with two frames held: the next frame closes a set of three
        settle(16);
        write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd4);
        write_reg(cas_pkg::CFG_MAX_SPREAD, 16'd10);
        send_item(cas_pkg::KIND_FRAME, 16'd0, 16'd0, 16'd0, 16'd1);
        send_item(cas_pkg::KIND_FRAME, 16'd30, 16'd0, 16'd0, 16'd2);
        settle(16);
        write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd1);
        send_item(cas_pkg::KIND_FRAME, 16'd0, 16'd30, 16'd0, 16'd3);

        // random phases, each with its own register setting
        random_items = 0;
        phase = 0;
        while (random_items < 900)
        begin
            settle(16);
            // one long stretch with no idling on either side
            tx_idle_pct = (phase == 3) ? 0 : 33;
            rx_idle_pct = tx_idle_pct;

            case ($urandom_range(3))
                0: jit = 0;
                1: jit = 20;
                2: jit = 300;
                default: jit = 4000;
            endcase
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            cz = POS_W'($urandom);

            if (phase == 5)
            begin
                // single-frame sets while the receiver holds off: the block fills up
                write_reg(cas_pkg::CFG_FRAME_COUNT, 16'd1);
                write_reg(cas_pkg::CFG_MAX_SPREAD, CFG_W'($urandom_range(0, 400)));
                tx_idle_pct = 0;
                hold_req++;
                len = 40;
            end
            else
            begin
                case ($urandom_range(19))
                    0: fc = '0;
                    1: fc = 7'd64;
                    2: fc = 7'd127;
                    3: fc = FC_W'($urandom_range(65, 126));
                    4, 5, 6: fc = FC_W'($urandom_range(7, 63));
                    default: fc = FC_W'($urandom_range(1, 6));
                endcase
                if (fc == '0)
                    target = 1;
                else if (int'(fc) > MAX_FRAMES)
                    target = MAX_FRAMES;
                else
                    target = int'(fc);
                // upper data bits are not part of the frame count
                write_reg(cas_pkg::CFG_FRAME_COUNT, {9'($urandom), fc});
                case ($urandom_range(3))
                    0: write_reg(cas_pkg::CFG_MAX_SPREAD, 16'd0);
                    1: write_reg(cas_pkg::CFG_MAX_SPREAD, 16'hFFFF);
                    2: write_reg(cas_pkg::CFG_MAX_SPREAD,
                                 CFG_W'($urandom_range(0, 3 * jit + 10)));
                    default: write_reg(cas_pkg::CFG_MAX_SPREAD, CFG_W'($urandom));
                endcase
                len = (target > 8) ? target + int'($urandom_range(target))
                                   : int'($urandom_range(20, 60));
            end

            // mostly clustered frames, some anywhere, a few restarts breaking sets
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(24) == 0)
                    send_item(cas_pkg::KIND_RESTART, POS_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom), PTS_W'($urandom));
                else if ($urandom_range(9) == 0)
                    send_item(cas_pkg::KIND_FRAME, POS_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom), PTS_W'($urandom));
                else
                    send_item(cas_pkg::KIND_FRAME, near(cx, jit), near(cy, jit),
                              near(cz, jit), PTS_W'($urandom));
                random_items++;
            end
            phase++;
        end

        // drain, then give the block time to show any stray transaction
        settle(100);
        if (fail_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cas_pkg.sv
rtl/cas_ram.sv
rtl/cas_div.sv
rtl/cas_datapath.sv
rtl/cas_ctrl.sv
rtl/centroid_average_spread_check.sv
sim/centroid_average_checker.sv
sim/tb_centroid_average_spread_check.sv
